@@ rtl/gna_pkg.sv @@
package gna_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int DIST_BITS = 2 * COORD_BITS + 1;
   localparam int OUT_IDX_BITS = 6;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_REGION = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                    mode;
      logic signed [COORD_BITS-1:0]  center_x;
      logic signed [COORD_BITS-1:0]  center_y;
      logic signed [COORD_BITS-1:0]  region_left;
      logic signed [COORD_BITS-1:0]  region_top;
      logic signed [COORD_BITS-1:0]  region_right;
      logic signed [COORD_BITS-1:0]  region_bottom;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_BITS-1:0] chosen_index;
      logic                    found;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic start_scan;
      logic issue;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic pipe_busy;
   } status_type;

endpackage

@@ rtl/gna_ctrl.sv @@
module gna_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          mode,
   input  gna_pkg::status_type status,
   output gna_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   gna_pkg::state_type state_ff;
   gna_pkg::state_type state_in;
   logic               accept;

   assign accept = start && (state_ff == gna_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gna_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gna_pkg::ST_IDLE: begin
            if (accept && (mode == gna_pkg::MODE_REGION)) begin
               state_in = gna_pkg::ST_SCAN;
            end
         end
         gna_pkg::ST_SCAN: begin
            if (!status.more) begin
               state_in = gna_pkg::ST_DRAIN;
            end
         end
         gna_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = gna_pkg::ST_REPLY;
            end
         end
         gna_pkg::ST_REPLY: begin
            state_in = gna_pkg::ST_IDLE;
         end
         default: begin
            state_in = gna_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         gna_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.load = accept && (mode == gna_pkg::MODE_LOAD);
            cmd.clear = accept && (mode == gna_pkg::MODE_CLEAR);
            cmd.start_scan = accept && (mode == gna_pkg::MODE_REGION);
         end
         gna_pkg::ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         gna_pkg::ST_DRAIN: begin
         end
         gna_pkg::ST_REPLY: begin
            cmd.reply = 1'b1;
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/gna_datapath.sv @@
module gna_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gna_pkg::req_type    req_item,
   input  gna_pkg::cmd_type    cmd,
   output gna_pkg::status_type status,
   output gna_pkg::rsp_type    rsp_item
);

   localparam int C = gna_pkg::COORD_BITS;

   logic [2*C-1:0] mem [gna_pkg::MAX_ENTRIES];

   logic [gna_pkg::MAX_ENTRIES-1:0] marks_ff;
   logic [gna_pkg::CNT_BITS-1:0]    count_ff;
   logic [gna_pkg::CNT_BITS-1:0]    idx_ff;
   logic signed [C-1:0]             cx_ff;
   logic signed [C-1:0]             cy_ff;

   logic [2*C-1:0]                  rd_ff;
   logic                            v1_ff, v2_ff, v3_ff;
   logic [gna_pkg::IDX_BITS-1:0]    i1_ff, i2_ff, i3_ff;
   logic [C-1:0]                    ax_ff, ay_ff;
   logic [2*C-1:0]                  sqx_ff, sqy_ff;

   logic                            have_ff;
   logic [gna_pkg::IDX_BITS-1:0]    best_ff;
   logic [gna_pkg::DIST_BITS-1:0]   best_d_ff;

   logic                            full;
   logic                            more;
   logic [gna_pkg::IDX_BITS-1:0]    addr;
   logic [gna_pkg::IDX_BITS-1:0]    load_addr;
   logic signed [C:0]               sum_x, sum_y;
   logic signed [C:0]               half_x, half_y;
   logic signed [C:0]               dx, dy;
   logic [C:0]                      neg_dx, neg_dy;
   logic [gna_pkg::DIST_BITS-1:0]   dist_sum;

   assign full = (count_ff == gna_pkg::CNT_BITS'(gna_pkg::MAX_ENTRIES));
   assign more = (idx_ff < count_ff);
   assign addr = idx_ff[gna_pkg::IDX_BITS-1:0];
   assign load_addr = count_ff[gna_pkg::IDX_BITS-1:0];

   // region center, halved toward zero
   assign sum_x = (C+1)'(req_item.region_left) + (C+1)'(req_item.region_right);
   assign sum_y = (C+1)'(req_item.region_top) + (C+1)'(req_item.region_bottom);
   assign half_x = (sum_x + (C+1)'(sum_x[C])) >>> 1;
   assign half_y = (sum_y + (C+1)'(sum_y[C])) >>> 1;

   assign dx = (C+1)'(signed'(rd_ff[2*C-1:C])) - (C+1)'(cx_ff);
   assign dy = (C+1)'(signed'(rd_ff[C-1:0])) - (C+1)'(cy_ff);
   assign neg_dx = -dx;
   assign neg_dy = -dy;

   assign dist_sum = gna_pkg::DIST_BITS'(sqx_ff) + gna_pkg::DIST_BITS'(sqy_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[load_addr] <= {req_item.center_x, req_item.center_y};
      end
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
         count_ff <= '0;
         idx_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            marks_ff <= '0;
            count_ff <= '0;
         end else if (cmd.load && !full) begin
            marks_ff[load_addr] <= 1'b0;
            count_ff <= count_ff + 1'b1;
         end else if (cmd.reply && have_ff) begin
            marks_ff[best_ff] <= 1'b1;
         end
         if (cmd.start_scan) begin
            idx_ff <= '0;
         end else if (cmd.issue && more) begin
            idx_ff <= idx_ff + 1'b1;
         end
         v1_ff <= cmd.issue && more && !marks_ff[addr];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (cmd.start_scan) begin
            have_ff <= 1'b0;
         end else if (v3_ff && (!have_ff || (dist_sum < best_d_ff))) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         cx_ff <= half_x[C-1:0];
         cy_ff <= half_y[C-1:0];
      end
      i1_ff <= addr;
      i2_ff <= i1_ff;
      i3_ff <= i2_ff;
      ax_ff <= dx[C] ? neg_dx[C-1:0] : dx[C-1:0];
      ay_ff <= dy[C] ? neg_dy[C-1:0] : dy[C-1:0];
      sqx_ff <= ax_ff * ax_ff;
      sqy_ff <= ay_ff * ay_ff;
      if (v3_ff && (!have_ff || (dist_sum < best_d_ff))) begin
         best_ff <= i3_ff;
         best_d_ff <= dist_sum;
      end
   end

   assign status.more = more;
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff;

   assign rsp_item.found = have_ff;
   assign rsp_item.chosen_index = have_ff ? gna_pkg::OUT_IDX_BITS'(best_ff) : '0;

endmodule

@@ rtl/greedy_nearest_assignment_top.sv @@
// Greedy nearest-center assignment.
// Input: an item is taken when start is high and busy is low. The mode field
// selects: load a center (append; ignored when the table is full), place a
// region, or clear the table. Load and clear finish in the accept cycle and
// give no result; busy stays low. Mode 3 is ignored.
// A region item raises busy. The block halves the region edges to a center,
// then scans the stored centers one per cycle through the table read port and
// a four-stage distance pipeline (read, difference, square, compare).
// The unassigned center nearest to the region center (earliest on a tie) is
// marked, and its index goes out with found on rsp_strobe for one cycle.
// After the scan of a region item the block waits for the pipeline to drain,
// then gives the result; busy drops in the cycle after the result.
// The receiver cannot stall; a result is valid only in its strobe cycle.
// Reset (synchronous) empties the table and clears all marks; table contents
// themselves are not reset and are read only after being loaded.
module greedy_nearest_assignment_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gna_pkg::req_type req_item,
   output logic             rsp_strobe,
   output gna_pkg::rsp_type rsp_item
);

   gna_pkg::cmd_type    cmd;
   gna_pkg::status_type status;

   gna_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .mode       (req_item.mode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   gna_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

@@ rtl/gna_checker.sv @@
module gna_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input gna_pkg::req_type req_item,
   input logic             rsp_strobe,
   input gna_pkg::rsp_type rsp_item
);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside busy window");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not single or busy held");

   a_region_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode == gna_pkg::MODE_REGION)) |=> busy)
      else $error("region item did not raise busy");

   a_other_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode != gna_pkg::MODE_REGION)) |=> !busy && !rsp_strobe)
      else $error("non-region item raised busy or a result");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.found) |-> (rsp_item.chosen_index == '0))
      else $error("index nonzero without found");

endmodule

bind greedy_nearest_assignment_top gna_checker u_gna_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

@@ bench/assignment_checker.sv @@
module assignment_checker
   import gna_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      mismatches,
   output int      picks_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   logic signed [COORD_BITS-1:0] tab_x [MAX_ENTRIES];
   logic signed [COORD_BITS-1:0] tab_y [MAX_ENTRIES];
   bit                           taken [MAX_ENTRIES];
   int unsigned                  entries;
   rsp_type                      expected_picks [$];
   int                           error_total;

   initial begin
      mismatches = 0;
      picks_pending = 0;
      error_total = 0;
      entries = 0;
   end

   // nearest unassigned center to the region center; earliest wins a tie
   function automatic rsp_type claim_nearest(input req_type it);
      longint             cx;
      longint             cy;
      longint             dx;
      longint             dy;
      logic [DIST_BITS:0] sq_dist;
      logic [DIST_BITS:0] best_dist;
      int                 best;
      bit                 have;
      rsp_type            pick;
      cx = (longint'($signed(it.region_left)) + longint'($signed(it.region_right))) / 2;
      cy = (longint'($signed(it.region_top)) + longint'($signed(it.region_bottom))) / 2;
      have = 0;
      best = 0;
      best_dist = '0;
      for (int i = 0; i < entries; i++) begin
         if (!taken[i]) begin
            dx = longint'(tab_x[i]) - cx;
            dy = longint'(tab_y[i]) - cy;
            sq_dist = (DIST_BITS+1)'(dx * dx + dy * dy);
            if (!have || sq_dist < best_dist) begin
               have = 1;
               best = i;
               best_dist = sq_dist;
            end
         end
      end
      pick.chosen_index = '0;
      pick.found = 1'b0;
      if (have) begin
         taken[best] = 1;
         pick.chosen_index = best[OUT_IDX_BITS-1:0];
         pick.found = 1'b1;
      end
      return pick;
   endfunction

   task automatic note_mismatch(input bit orphan, input rsp_type want, input rsp_type got);
      error_total++;
      if (error_total <= 10) begin
         if (orphan)
            $display("checker: result with none expected: index %0d found %0b",
                     got.chosen_index, got.found);
         else
            $display("checker: mismatch: expected index %0d found %0b, got index %0d found %0b",
                     want.chosen_index, want.found, got.chosen_index, got.found);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         entries = 0;
         for (int i = 0; i < MAX_ENTRIES; i++)
            taken[i] = 0;
         expected_picks.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_picks.size() == 0) begin
               note_mismatch(1, rsp_item, rsp_item);
            end else begin
               want = expected_picks.pop_front();
               if (rsp_item.chosen_index !== want.chosen_index || rsp_item.found !== want.found)
                  note_mismatch(0, want, rsp_item);
            end
         end
         if (start && !busy) begin
            case (req_item.mode)
               MODE_LOAD: begin
                  if (entries < MAX_ENTRIES) begin
                     tab_x[entries] = req_item.center_x;
                     tab_y[entries] = req_item.center_y;
                     taken[entries] = 0;
                     entries++;
                  end
               end
               MODE_CLEAR: begin
                  entries = 0;
                  for (int i = 0; i < MAX_ENTRIES; i++)
                     taken[i] = 0;
               end
               MODE_REGION: expected_picks = {expected_picks, claim_nearest(req_item)};
               default: ;
            endcase
         end
      end
      picks_pending <= expected_picks.size();
      mismatches <= error_total;
   end

endmodule

@@ bench/testbench.sv @@
module testbench;

   import gna_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REQ_BITS = $bits(req_type);
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int errors;
   int pending;
   int cycles = 0;
   int items = 0;
   int loaded = 0;
   int idle_pct = 10;

   greedy_nearest_assignment_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   assignment_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .mismatches    (errors),
      .picks_pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3, 4: return COORD_BITS'($urandom_range(16) - 8);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type noisy_item(input logic [1:0] mode);
      req_type it;
      it = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
      it.mode = mode;
      return it;
   endfunction

   function automatic req_type load_item(input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y);
      req_type it;
      it = noisy_item(MODE_LOAD);
      it.center_x = x;
      it.center_y = y;
      return it;
   endfunction

   function automatic req_type region_item(input logic signed [COORD_BITS-1:0] l,
                                           input logic signed [COORD_BITS-1:0] t,
                                           input logic signed [COORD_BITS-1:0] r,
                                           input logic signed [COORD_BITS-1:0] b);
      req_type it;
      it = noisy_item(MODE_REGION);
      it.region_left = l;
      it.region_top = t;
      it.region_right = r;
      it.region_bottom = b;
      return it;
   endfunction

   task automatic send(input req_type it);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      case (it.mode)
         MODE_LOAD: begin
            if (loaded < MAX_ENTRIES) begin
               loaded++;
               items++;
            end
         end
         MODE_CLEAR: begin
            loaded = 0;
            items++;
         end
         MODE_REGION: items++;
         default: ;
      endcase
      idle_pct = (items < ITEM_TARGET / 3) ? 10 : (items < 2 * ITEM_TARGET / 3) ? 69 : 0;
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int n;
      int regions;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send(region_item(0, 0, 0, 0));
      send(load_item(16'sh7fff, 16'sh7fff));
      send(load_item(16'sh8000, 16'sh8000));
      send(load_item(0, 0));
      send(load_item(0, 0));
      send(load_item(-2, -2));
      // center truncates toward zero: three-way tie, earliest wins
      send(region_item(-3, -3, 0, 0));
      send(region_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
      send(region_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      send(region_item(-3, -3, 0, 0));
      send(region_item(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000));
      send(region_item(0, 0, 0, 0));
      send(noisy_item(MODE_UNUSED));
      send(noisy_item(MODE_CLEAR));
      send(region_item(1, 1, 1, 1));
      send(load_item(16'sh7fff, 16'sh8000));
      send(load_item(16'sh8000, 16'sh7fff));
      send(region_item(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
      // largest possible distance
      send(region_item(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
      send(load_item(5, 5));
      send(region_item(5, 5, 5, 5));
      send(noisy_item(MODE_CLEAR));
      drain();

      while (items < ITEM_TARGET) begin
         n = ($urandom_range(9) < 2) ? $urandom_range(60, 70) : $urandom_range(0, 20);
         regions = $urandom_range(1, n + 3);
         if ($urandom_range(9) < 8)
            send(noisy_item(MODE_CLEAR));
         repeat (n) begin
            if ($urandom_range(19) == 0)
               send(noisy_item(2'($urandom_range(3))));
            else
               send(load_item(pick_coord(), pick_coord()));
         end
         repeat (regions) begin
            if ($urandom_range(19) == 0)
               send(noisy_item(2'($urandom_range(3))));
            else
               send(region_item(pick_coord(), pick_coord(), pick_coord(), pick_coord()));
         end
         if ($urandom_range(7) == 0)
            drain();
      end

      drain();
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
